// File: rtl/mrlm_pkg.sv
// Package for the modem response line matcher: reply texts, lengths,
// match codes and the structs passed between the step logic and the top level.
// No dependencies.
package mrlm_pkg;

  localparam int unsigned LINE_CAP    = 40;
  localparam int unsigned NUM_REPLIES = 4;
  localparam int unsigned REPLY_MAX   = 10;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned TEXT_IDX_W  = $clog2(REPLY_MAX);

  localparam logic [7:0] LINE_END_LIMIT = 8'h20;
  localparam logic [7:0] UPPER_FIRST    = 8'h41;
  localparam logic [7:0] UPPER_LAST     = 8'h5a;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  typedef enum logic [2:0] {
    MATCH_NONE       = 3'd0,
    MATCH_CALL_READY = 3'd1,
    MATCH_NO_CARRIER = 3'd2,
    MATCH_OK         = 3'd3,
    MATCH_RING       = 3'd4
  } match_code_e;

  localparam logic [7:0] REPLY_TEXT [NUM_REPLIES][REPLY_MAX] = '{
    '{8'h63, 8'h61, 8'h6c, 8'h6c, 8'h20, 8'h72, 8'h65, 8'h61, 8'h64, 8'h79},
    '{8'h6e, 8'h6f, 8'h20, 8'h63, 8'h61, 8'h72, 8'h72, 8'h69, 8'h65, 8'h72},
    '{8'h6f, 8'h6b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h69, 8'h6e, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [POS_W-1:0] REPLY_LEN [NUM_REPLIES] = '{
    6'd10, 6'd10, 6'd2, 6'd4
  };

  localparam match_code_e REPLY_CODE [NUM_REPLIES] = '{
    MATCH_CALL_READY, MATCH_NO_CARRIER, MATCH_OK, MATCH_RING
  };

  typedef struct packed {
    logic [POS_W-1:0]       pos;
    logic [NUM_REPLIES-1:0] alive;
  } line_state_t;

  typedef struct packed {
    logic             line_done;
    match_code_e      match_code;
    logic [POS_W-1:0] line_length;
  } line_result_t;

endpackage

// File: rtl/mrlm_step.sv
// Per-byte logic of the line matcher: case fold, prefix compare against the
// four replies, position update and end-of-line report. Uses mrlm_pkg.
module mrlm_step (
  input  logic [7:0]             rx_byte_i,
  input  mrlm_pkg::line_state_t  state_i,
  output mrlm_pkg::line_state_t  state_o,
  output mrlm_pkg::line_result_t result_o
);

  logic [7:0]                          folded;
  logic [mrlm_pkg::NUM_REPLIES-1:0]    char_ok;
  logic [mrlm_pkg::POS_W-1:0]          pos_inc;
  mrlm_pkg::match_code_e               code;

  always_comb begin
    folded = rx_byte_i;
    if (rx_byte_i >= mrlm_pkg::UPPER_FIRST && rx_byte_i <= mrlm_pkg::UPPER_LAST) begin
      folded = rx_byte_i + mrlm_pkg::CASE_OFFSET;
    end
  end

  always_comb begin
    for (int k = 0; k < mrlm_pkg::NUM_REPLIES; k++) begin
      char_ok[k] = (state_i.pos < mrlm_pkg::REPLY_LEN[k]) &&
                   (mrlm_pkg::REPLY_TEXT[k][state_i.pos[mrlm_pkg::TEXT_IDX_W-1:0]]
                    == folded);
    end
  end

  // exact match: still alive and the line is as long as the reply
  always_comb begin
    code = mrlm_pkg::MATCH_NONE;
    for (int k = 0; k < mrlm_pkg::NUM_REPLIES; k++) begin
      if (state_i.alive[k] && state_i.pos == mrlm_pkg::REPLY_LEN[k]) begin
        code = mrlm_pkg::REPLY_CODE[k];
      end
    end
  end

  assign pos_inc = state_i.pos + 1'b1;

  always_comb begin
    state_o  = state_i;
    result_o = '{line_done: 1'b0, match_code: mrlm_pkg::MATCH_NONE, line_length: '0};
    if (rx_byte_i < mrlm_pkg::LINE_END_LIMIT) begin
      // terminator on an empty line leaves everything alone
      if (state_i.pos != '0) begin
        result_o.line_done   = 1'b1;
        result_o.match_code  = code;
        result_o.line_length = state_i.pos;
        state_o.pos          = '0;
        state_o.alive        = '1;
      end
    end else begin
      state_o.alive = state_i.alive & char_ok;
      state_o.pos   = pos_inc;
      // overflow: wrap and restart matching
      if (pos_inc >= mrlm_pkg::POS_W'(mrlm_pkg::LINE_CAP)) begin
        state_o.pos   = '0;
        state_o.alive = '1;
      end
    end
  end

endmodule

// File: rtl/modem_response_line_matcher.sv
// Modem response line matcher, top level: input register, line state,
// result register. Uses mrlm_pkg and mrlm_step.
// The result is registered (input reg -> step logic -> result reg); a stall from the
// receiver holds the byte in the input register until the result register is free.
// Throughput: one byte per cycle while the receiver does not stall; the per-byte compare
// and position update are combinational between the input and result registers.
// Reset (async, active low): position 0, all replies alive, both stages empty.
module modem_response_line_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       line_done_o,
  output logic [2:0] match_code_o,
  output logic [5:0] line_length_o
);

  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   advance;
  mrlm_pkg::line_state_t  state_q, state_d;
  mrlm_pkg::line_result_t result_d, result_q;
  logic                   out_valid_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  mrlm_step u_step (
    .rx_byte_i (byte_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pos   <= '0;
      state_q.alive <= '1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_done_o   = result_q.line_done;
  assign match_code_o  = result_q.match_code;
  assign line_length_o = result_q.line_length;

  a_pos_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos < mrlm_pkg::POS_W'(mrlm_pkg::LINE_CAP))
    else $error("line position reached LINE_CAP");

  a_idle_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_done_o |->
      match_code_o == mrlm_pkg::MATCH_NONE && line_length_o == '0)
    else $error("result fields set without line done");

  a_done_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> line_length_o != '0)
    else $error("line done on empty line");

  a_ok_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o && match_code_o == mrlm_pkg::MATCH_OK |->
      line_length_o == mrlm_pkg::REPLY_LEN[2])
    else $error("ok match with wrong length");

  a_state_reset_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && result_d.line_done |=> state_q.pos == '0 && state_q.alive == '1)
    else $error("line state not restarted after line end");

endmodule

// File: dv/line_reply_checker.sv
// Checker for the modem response line matcher: watches both channels, predicts each
// result from the accepted bytes and compares it field by field.
// Depends on mrlm_pkg for the result struct, match codes and LINE_CAP.
module line_reply_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       line_done_i,
  input  logic [2:0] match_code_i,
  input  logic [5:0] line_length_i,
  output int         err_cnt_o,
  output int         pending_o
);

  localparam logic [7:0] REPLY_CHARS [4][10] = '{
    '{"c", "a", "l", "l", " ", "r", "e", "a", "d", "y"},
    '{"n", "o", " ", "c", "a", "r", "r", "i", "e", "r"},
    '{"o", "k", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "i", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int unsigned REPLY_SIZE [4] = '{10, 10, 2, 4};
  localparam mrlm_pkg::match_code_e REPLY_MATCH [4] = '{
    mrlm_pkg::MATCH_CALL_READY, mrlm_pkg::MATCH_NO_CARRIER, mrlm_pkg::MATCH_OK,
    mrlm_pkg::MATCH_RING
  };

  mrlm_pkg::line_state_t  line_st;
  mrlm_pkg::line_result_t expected_lines [$];
  int                     mismatches;

  // One byte through the line tracker: returns the result it causes.
  function automatic mrlm_pkg::line_result_t advance_line(input logic [7:0] rx,
                                                          inout mrlm_pkg::line_state_t st);
    mrlm_pkg::line_result_t res;
    logic [7:0]             ch;
    logic                   hit;
    res.line_done   = 1'b0;
    res.match_code  = mrlm_pkg::MATCH_NONE;
    res.line_length = '0;
    if (rx < 8'h20) begin
      if (st.pos != '0) begin
        res.line_done   = 1'b1;
        res.line_length = st.pos;
        for (int k = 0; k < 4; k++) begin
          if (st.alive[k] && st.pos == REPLY_SIZE[k]) res.match_code = REPLY_MATCH[k];
        end
        st.pos   = '0;
        st.alive = '1;
      end
    end else begin
      ch = (rx >= "A" && rx <= "Z") ? rx + 8'h20 : rx;
      for (int k = 0; k < 4; k++) begin
        hit = 1'b0;
        if (st.pos < REPLY_SIZE[k]) begin
          hit = (REPLY_CHARS[k][st.pos] == ch);
        end
        if (!hit) st.alive[k] = 1'b0;
      end
      st.pos = st.pos + 1'b1;
      // wrap: matching restarts with the next character
      if (st.pos >= mrlm_pkg::LINE_CAP) begin
        st.pos   = '0;
        st.alive = '1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mrlm_pkg::line_result_t exp_res;
    mrlm_pkg::line_state_t  st;
    if (!rst_ni) begin
      line_st.pos   <= '0;
      line_st.alive <= '1;
      expected_lines.delete();
      mismatches = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // a result always leaves after the byte that caused it, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result: done=%0d code=%0d len=%0d", $time,
                     line_done_i, match_code_i, line_length_i);
          end
        end else begin
          exp_res = expected_lines.pop_front();
          if (line_done_i !== exp_res.line_done || match_code_i !== exp_res.match_code ||
              line_length_i !== exp_res.line_length) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: exp done=%0d code=%0d len=%0d,",
                       $time, exp_res.line_done, exp_res.match_code, exp_res.line_length,
                       " got done=%0d code=%0d len=%0d",
                       line_done_i, match_code_i, line_length_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        st = line_st;
        expected_lines.push_back(advance_line(rx_byte_i, st));
        line_st <= st;
      end
      err_cnt_o <= mismatches;
      pending_o <= expected_lines.size();
    end
  end

endmodule

// File: dv/tb_modem_response_line_matcher.sv
// Testbench top for the modem response line matcher: clock, reset, byte stimulus,
// receiver stall pattern, watchdog and verdict.
// Depends on mrlm_pkg, modem_response_line_matcher and line_reply_checker.
module tb_modem_response_line_matcher;

  localparam int NUM_BYTES      = 1600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_EVERY    = 500;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       line_done_o;
  logic [2:0] match_code_o;
  logic [5:0] line_length_o;

  int err_cnt;
  int pending;
  int idle_cycles = 0;
  int burst_left  = 0;
  int sent        = 0;

  logic [1:0] stall_mode = 2'd0;
  int         mode_left  = 0;

  logic [7:0] line_buf [$];
  string      reply_txt [4] = '{"call ready", "no carrier", "ok", "ring"};

  always #4 clk_i = ~clk_i;

  modem_response_line_matcher u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_done_o  (line_done_o),
    .match_code_o (match_code_o),
    .line_length_o(line_length_o)
  );

  line_reply_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_done_i  (line_done_o),
    .match_code_i (match_code_o),
    .line_length_i(line_length_o),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending)
  );

  // Receiver: stall mode is redrawn at random whenever its countdown runs out
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      mode_left  <= $urandom_range(16, 128);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (mode_left % 3 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called right after a rising edge; returns right after the transfer edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        rx_byte_i  <= 8'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_char();
    return 8'($urandom_range(8'h20, 8'hff));
  endfunction

  task automatic add_reply(input int r);
    for (int i = 0; i < reply_txt[r].len(); i++) line_buf.push_back(mix_case(reply_txt[r][i]));
  endtask

  // send the line buffer, then a random control byte
  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
    send_byte(8'($urandom_range(0, 8'h1f)));
  endtask

  initial begin
    logic [7:0] directed [$];
    int         kind;
    int         r;
    int         n;
    int         next_drain;

    // empty terminator, ok, RiNg, odd bytes, ok too long, case-fold edges
    directed = '{8'h00,
                 8'h6f, 8'h6b, 8'h0d,
                 8'h52, 8'h69, 8'h4e, 8'h67, 8'h0a,
                 8'hff, 8'h80, 8'h20, 8'h7f, 8'h1f,
                 8'h6f, 8'h6b, 8'h78, 8'h00,
                 8'h41, 8'h5a, 8'h60, 8'h7b, 8'h40, 8'h5b, 8'h0d};
    next_drain = DRAIN_EVERY;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i]);

    while (sent < NUM_BYTES) begin
      kind = $urandom_range(0, 99);
      r    = $urandom_range(0, 3);
      if (kind < 35) begin
        add_reply(r);
        send_line();
      end else if (kind < 55) begin
        // near misses: truncated, one char changed, or extra chars
        add_reply(r);
        case ($urandom_range(0, 2))
          0: begin
            n = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > n) void'(line_buf.pop_back());
          end
          1: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(8'h20, 8'h7e));
          default: repeat ($urandom_range(1, 3)) line_buf.push_back(rand_char());
        endcase
        send_line();
      end else if (kind < 75) begin
        n = ($urandom_range(0, 7) == 0)
              ? $urandom_range(mrlm_pkg::LINE_CAP - 2, mrlm_pkg::LINE_CAP + 2)
              : $urandom_range(1, 12);
        repeat (n) line_buf.push_back(rand_char());
        send_line();
      end else if (kind < 85) begin
        // long prefix that wraps the position, then a reply
        case ($urandom_range(0, 3))
          0: n = mrlm_pkg::LINE_CAP - 1;
          1: n = mrlm_pkg::LINE_CAP;
          2: n = mrlm_pkg::LINE_CAP + 1;
          default: n = 2 * mrlm_pkg::LINE_CAP;
        endcase
        repeat (n) line_buf.push_back(rand_char());
        add_reply(r);
        send_line();
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 8'h1f)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mrlm_pkg.sv
rtl/mrlm_step.sv
rtl/modem_response_line_matcher.sv
dv/line_reply_checker.sv
dv/tb_modem_response_line_matcher.sv
